FILE: hdl/tmw_pkg.sv
// Shared types and constants for the text-mode terminal writer.
package tmw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_CELL  = {RESET_COLOR, BLANK_CODE};

  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_READ_NONE
  } tmw_op_t;

  typedef struct packed {
    tmw_op_t    op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tmw_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_COPY,
    ST_FILL,
    ST_RESP
  } tmw_state_t;

endpackage

FILE: hdl/tmw_front.sv
// Front end: accepts input items and classifies them into commands.
module tmw_front import tmw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_char_code,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  input  logic       q_full,
  input  logic       clearing,
  output logic       q_push,
  output tmw_cmd_t   q_data
);

  logic in_range;

  assign in_range = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);

  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data.char_code = in_char_code;
    q_data.read_row  = in_read_row;
    q_data.read_col  = in_read_col;
    priority if (in_kind) begin
      q_data.op = in_range ? OP_READ : OP_READ_NONE;
    end else if (in_char_code == NEWLINE_CODE) begin
      q_data.op = OP_NEWLINE;
    end else begin
      q_data.op = OP_PUT;
    end
  end

endmodule

FILE: hdl/tmw_fifo.sv
// Short command queue between the front end and the execution engine.
module tmw_fifo import tmw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_push,
  input  tmw_cmd_t q_wdata,
  input  logic     q_pop,
  output tmw_cmd_t q_rdata,
  output logic     q_full,
  output logic     q_empty
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);
  localparam logic [NW-1:0] CNT_FULL = NW'(Q_DEPTH);

  tmw_cmd_t        q_mem [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign q_rdata = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({q_push, q_pop})
      2'b10:   cnt_nxt = cnt_r + NW'(1);
      2'b01:   cnt_nxt = cnt_r - NW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

FILE: hdl/tmw_back.sv
// Execution engine: cell store, cursor, scroll sequencer and result register.
module tmw_back import tmw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        q_empty,
  input  tmw_cmd_t    q_data,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_value,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic        out_scrolled
);

  localparam int TOTAL = ROWS * COLUMNS;
  localparam int AW    = $clog2(TOTAL);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A   = AW'(TOTAL - 1);
  localparam logic [AW-1:0] COPY_N_A = AW'((ROWS - 1) * COLUMNS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  logic [15:0]   mem [TOTAL];

  tmw_state_t    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  tmw_cmd_t      cmd_r;
  logic [7:0]    color_r;
  logic [15:0]   rdata_r;
  logic [15:0]   res_cell_r;
  logic          res_scr_r;
  logic          out_valid_r;
  logic [15:0]   out_cell_r;
  logic [4:0]    out_row_r;
  logic [6:0]    out_col_r;
  logic          out_scr_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;
  logic          fin, fin_scr, scroll;
  logic [15:0]   fin_cell;
  logic          out_free, load_out;
  logic          col_last, row_last;
  logic [AW-1:0] cur_addr, rd_addr;

  assign col_last = (cur_col_r == COL_LAST);
  assign row_last = (cur_row_r == ROW_LAST);
  assign out_free = !out_valid_r || out_ready;
  assign cur_addr = AW'(AW'(cur_row_r) * COLS_A + AW'(cur_col_r));
  assign rd_addr  = AW'(AW'(cmd_r.read_row) * COLS_A + AW'(cmd_r.read_col));
  assign clearing = (state_r == ST_CLEAR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (cnt_r == LAST_A) state_nxt = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_nxt = ST_EXEC;
      ST_EXEC: begin
        priority if (cmd_r.op == OP_READ) state_nxt = ST_RDATA;
        else if (scroll)                  state_nxt = ST_COPY;
        else                              state_nxt = out_free ? ST_IDLE : ST_RESP;
      end
      ST_RDATA: state_nxt = out_free ? ST_IDLE : ST_RESP;
      ST_COPY:  if (cnt_r == COPY_N_A) state_nxt = ST_FILL;
      ST_FILL: begin
        if (cnt_r == LAST_A) state_nxt = out_free ? ST_IDLE : ST_RESP;
      end
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control and datapath outputs
  always_comb begin
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cnt_r;
    mem_raddr   = rd_addr;
    mem_wdata   = {color_r, BLANK_CODE};
    cnt_nxt     = cnt_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    fin         = 1'b0;
    fin_cell    = '0;
    fin_scr     = 1'b0;
    scroll      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        cnt_nxt   = (cnt_r == LAST_A) ? '0 : cnt_r + AW'(1);
      end
      ST_IDLE: q_pop = !q_empty;
      ST_EXEC: begin
        unique case (cmd_r.op)
          OP_READ:      mem_re = 1'b1;
          OP_READ_NONE: fin = 1'b1;
          OP_PUT, OP_NEWLINE: begin
            if (cmd_r.op == OP_PUT) begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {color_r, cmd_r.char_code};
            end
            if (cmd_r.op == OP_PUT && !col_last) begin
              cur_col_nxt = cur_col_r + CW'(1);
            end else begin
              cur_col_nxt = '0;
              if (row_last) scroll = 1'b1;
              else          cur_row_nxt = cur_row_r + RW'(1);
            end
            fin     = !scroll;
            cnt_nxt = '0;
          end
          default: fin = 1'b1;
        endcase
      end
      ST_RDATA: begin
        fin      = 1'b1;
        fin_cell = rdata_r;
      end
      // Read one row ahead, write the previous read one row up
      ST_COPY: begin
        mem_re    = (cnt_r != COPY_N_A);
        mem_raddr = cnt_r + COLS_A;
        mem_we    = (cnt_r != '0);
        mem_waddr = cnt_r - AW'(1);
        mem_wdata = rdata_r;
        cnt_nxt   = (cnt_r == COPY_N_A) ? cnt_r : cnt_r + AW'(1);
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_A) begin
          fin     = 1'b1;
          fin_scr = 1'b1;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_RESP: begin
        fin_cell = res_cell_r;
        fin_scr  = res_scr_r;
      end
      default: fin = 1'b0;
    endcase
  end

  assign load_out = out_free && (fin || state_r == ST_RESP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      if (cfg_wr_en) color_r <= cfg_wr_data;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_data;
    // Hold the result while the output register is still occupied
    if (fin && !out_free) begin
      res_cell_r <= fin_cell;
      res_scr_r  <= fin_scr;
    end
    if (load_out) begin
      out_cell_r <= fin_cell;
      out_row_r  <= 5'(cur_row_nxt);
      out_col_r  <= 7'(cur_col_nxt);
      out_scr_r  <= fin_scr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scr_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_row_r <= ROW_LAST && cur_col_r <= COL_LAST)
    else $error("cursor out of range");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && cnt_r == LAST_A) |-> (cur_row_r == ROW_LAST && cur_col_r == '0))
    else $error("scroll finished with cursor off the last row start");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same cell in one cycle");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass restarted without reset");

  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_EXEC))
    else $error("popped item not executed");

endmodule

FILE: hdl/text_mode_terminal_writer.sv
// Top level of the text-mode terminal writer: front end, queue, execution engine.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_kind, in_char_code, in_read_row, in_read_col
//   out      output     out_valid/out_ready  out_cell_value, out_cursor_row, out_cursor_col,
//                                            out_scrolled
//   cfg      input      cfg_wr_en            cfg_wr_data (text color)
//
// A character, a newline or an out-of-range read passes the engine's idle and execute states;
// an in-range read also passes the read-data state, set by the registered read port of the
// cell store. A scroll adds a row copy up one row and a blank fill of the last row.
// After reset a clearing pass writes blanks to all ROWS*COLUMNS cells, one per cycle,
// with in_ready low; configuration writes are taken throughout.
// A two-entry queue keeps accepting items while a result waits in the output register.
module text_mode_terminal_writer import tmw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_value,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic        out_scrolled
);

  tmw_cmd_t push_data, pop_data;
  logic     q_push, q_pop, q_full, q_empty, clearing;

  tmw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .q_full       (q_full),
    .clearing     (clearing),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  tmw_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (push_data),
    .q_pop   (q_pop),
    .q_rdata (pop_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tmw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench for text_mode_terminal_writer: directed table, then random text.
module tb;
  import tmw_pkg::*;

  localparam int SCR_COLS     = 80;
  localparam int SCR_ROWS     = 25;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int MAX_REPORTS  = 100;
  localparam int PHASE_ITEMS  = 230;
  localparam int NUM_PHASES   = 8;
  localparam int DRAIN_CYCLES = 50;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [15:0] cell_val;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } term_result_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   ch;
    logic [4:0]   row;
    logic [6:0]   col;
    logic         typed;
    term_result_t res;
  } stim_row_t;

  localparam int NUM_DIRECTED = 23;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{KIND_READ, 8'h00, 5'd0, 7'd0, 1'b1, '{RESET_CELL, 5'd0, 7'd0, 1'b0}},
    '{KIND_READ, 8'hFF, 5'd24, 7'd79, 1'b1, '{RESET_CELL, 5'd0, 7'd0, 1'b0}},
    '{KIND_READ, 8'h00, 5'd25, 7'd0, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{KIND_READ, 8'h00, 5'd0, 7'd80, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{KIND_READ, 8'h00, 5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{KIND_PUT, 8'h41, 5'd31, 7'd127, 1'b0, '0},
    '{KIND_PUT, 8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_PUT, 8'hFF, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd0, 7'd2, 1'b0, '0},
    '{KIND_READ, NEWLINE_CODE, 5'd0, 7'd1, 1'b0, '0},
    '{KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_PUT, BLANK_CODE, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_PUT, 8'h7E, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd1, 7'd0, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd1, 7'd1, 1'b0, '0},
    '{KIND_PUT, 8'h0B, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_PUT, 8'h09, 5'd0, 7'd0, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd3, 7'd1, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd0, 7'd79, 1'b0, '0},
    '{KIND_READ, 8'h00, 5'd3, 7'd0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_PUT;
  logic [7:0]  in_char_code = 8'h00;
  logic [4:0]  in_read_row = 5'd0;
  logic [6:0]  in_read_col = 7'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_cell_value;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic        out_scrolled;

  // screen image, cursor and color as the block should hold them
  logic [15:0] scr_cells [SCR_ROWS*SCR_COLS];
  int          pos_row;
  int          pos_col;
  logic [7:0]  attr_color;

  term_result_t pending_results [$];
  int           error_count = 0;
  int           burst_left = 0;
  bit           steady_send = 1'b0;
  int           hold_reqs = 0;
  int           holds_served = 0;
  int           hold_cnt = 0;
  int unsigned  rcv_cycle = 0;
  int           rcv_mode = 0;
  int           idle_cycles = 0;

  always #4 clk = ~clk;

  text_mode_terminal_writer #(
    .COLUMNS(SCR_COLS),
    .ROWS   (SCR_ROWS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_value(out_cell_value),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_scrolled  (out_scrolled)
  );

  // Move the cursor down one row; scroll the screen when it falls off the bottom.
  function automatic logic next_line();
    pos_row++;
    if (pos_row < SCR_ROWS) return 1'b0;
    for (int i = 0; i < (SCR_ROWS - 1) * SCR_COLS; i++)
      scr_cells[i] = scr_cells[i + SCR_COLS];
    for (int c = 0; c < SCR_COLS; c++)
      scr_cells[(SCR_ROWS - 1) * SCR_COLS + c] = {attr_color, BLANK_CODE};
    pos_row = SCR_ROWS - 1;
    return 1'b1;
  endfunction

  function automatic term_result_t print_item(logic k, logic [7:0] c, logic [4:0] r,
                                              logic [6:0] cl);
    term_result_t res;
    res = '0;
    if (k == KIND_READ) begin
      if (r < SCR_ROWS && cl < SCR_COLS) res.cell_val = scr_cells[r * SCR_COLS + cl];
    end else if (c == NEWLINE_CODE) begin
      pos_col = 0;
      res.scrolled = next_line();
    end else begin
      scr_cells[pos_row * SCR_COLS + pos_col] = {attr_color, c};
      pos_col++;
      if (pos_col >= SCR_COLS) begin
        pos_col = 0;
        res.scrolled = next_line();
      end
    end
    res.row = pos_row[4:0];
    res.col = pos_col[6:0];
    return res;
  endfunction

  // Offer one item in bursts, with random gaps unless steady_send is set; record what it should return.
  task automatic offer(input logic k, input logic [7:0] c, input logic [4:0] r,
                       input logic [6:0] cl, input logic typed, input term_result_t typed_res);
    term_result_t res;
    if (burst_left == 0) begin
      if (!steady_send) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_char_code <= c;
    in_read_row  <= r;
    in_read_col  <= cl;
    do @(posedge clk); while (!in_ready);
    res = print_item(k, c, r, cl);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic offer_put(input logic [7:0] c);
    offer(KIND_PUT, c, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)), 1'b0, '0);
  endtask

  task automatic offer_read(input int r, input int cl);
    offer(KIND_READ, 8'($urandom_range(0, 255)), 5'(r), 7'(cl), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_text_color(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    attr_color = v;
  endtask

  // One random phase: lines of text, reads near the cursor, newlines and noise.
  task automatic run_phase(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 20);
          for (int i = 0; i < len; i++)
            offer_put(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(32, 126)));
          sent += len;
          if ($urandom_range(0, 1) == 1) begin
            offer_put(NEWLINE_CODE);
            sent++;
          end
        end
        4, 5, 6: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0)
              offer_read($urandom_range(0, SCR_ROWS - 1), $urandom_range(0, SCR_COLS - 1));
            else if (pos_col > 0 && $urandom_range(0, 1) == 1)
              offer_read(pos_row, $urandom_range(0, pos_col - 1));
            else
              offer_read(pos_row, $urandom_range(0, SCR_COLS - 1));
          end
          sent += len;
        end
        7: begin
          len = $urandom_range(1, 2);
          repeat (len) offer_put(NEWLINE_CODE);
          sent += len;
        end
        8: begin
          len = $urandom_range(1, 4);
          repeat (len)
            offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)), 1'b0, '0);
          sent += len;
        end
        default: begin
          // edges of the screen and just past them
          case ($urandom_range(0, 3))
            0: offer_read(SCR_ROWS - 1, SCR_COLS - 1);
            1: offer_read($urandom_range(SCR_ROWS, 31), $urandom_range(0, 127));
            2: offer_read($urandom_range(0, 31), $urandom_range(SCR_COLS, 127));
            default: offer_read(0, 0);
          endcase
          sent++;
        end
      endcase
    end
  endtask

  task automatic note_mismatch(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want_v, got_v);
  endtask

  // Result checker
  always @(posedge clk) begin
    term_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none expected, cell %h row %0d col %0d", $time,
                   out_cell_value, out_cursor_row, out_cursor_col);
      end else begin
        want = pending_results.pop_front();
        if (out_cell_value !== want.cell_val)
          note_mismatch("cell_value", want.cell_val, out_cell_value);
        if (out_cursor_row !== want.row)
          note_mismatch("cursor_row", 16'(want.row), 16'(out_cursor_row));
        if (out_cursor_col !== want.col)
          note_mismatch("cursor_col", 16'(want.col), 16'(out_cursor_col));
        if (out_scrolled !== want.scrolled)
          note_mismatch("scrolled", 16'(want.scrolled), 16'(out_scrolled));
      end
    end
  end

  // Receiver: changes its stall pattern now and then; long hold-off on request.
  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    if (rcv_cycle % 97 == 0) rcv_mode <= $urandom_range(0, 3);
    if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (holds_served < hold_reqs) begin
      holds_served <= holds_served + 1;
      hold_cnt     <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      case (rcv_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rcv_cycle[2];
      endcase
    end
  end

  // Watchdog: cycles without any accepted item on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("text_mode_terminal_writer test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_colors [NUM_PHASES];
    phase_colors = '{8'h00, 8'hFF, 8'h07, 8'h80, 8'h0F, 8'h00, 8'h00, 8'h00};
    for (int i = 0; i < SCR_ROWS * SCR_COLS; i++) scr_cells[i] = RESET_CELL;
    pos_row    = 0;
    pos_col    = 0;
    attr_color = RESET_COLOR;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_text_color(8'h1E);
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].row,
            DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_text_color((p >= 5) ? 8'($urandom_range(0, 255)) : phase_colors[p]);
      // stall the receiver while the sender keeps pushing, so the input backs up
      steady_send = (p == 1 || p == 4);
      if (steady_send) hold_reqs++;
      run_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("text_mode_terminal_writer test passed");
    else
      $display("text_mode_terminal_writer test failed");
    $finish;
  end

endmodule
